>>> hw/rtl/srp_pkg.sv
// srp_pkg: shared types, constants and helpers for the stun response parser
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

    localparam int unsigned OFF_W = 17;

    localparam logic [31:0]      COOKIE_VAL      = 32'h2112_A442;
    localparam logic [15:0]      TYPE_BIND_RESP  = 16'h0101;
    localparam logic [15:0]      ATTR_XOR_MAPPED = 16'h0020;
    localparam logic [15:0]      ATTR_MAPPED     = 16'h0001;
    localparam logic [7:0]       FAMILY_IPV4     = 8'h01;
    localparam logic [OFF_W-1:0] OFF_SAT         = 17'h1_FFFF;
    localparam logic [OFF_W-1:0] HDR_LEN         = 17'd20;
    localparam logic [15:0]      MIN_ADDR_LEN    = 16'd8;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_COOKIE   = 3'd2,
        ST_TYPE     = 3'd3,
        ST_OVERRUN  = 3'd4,
        ST_NO_ADDR  = 3'd5
    } srp_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } srp_in_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  status;
        logic [31:0] mapped_address;
        logic [15:0] mapped_port;
        logic        was_xored;
    } srp_out_t;

    // parser state as it stands after the current byte, handed to the verdict logic
    typedef struct packed {
        logic [OFF_W-1:0] pkt_len;
        logic             cookie_ok;
        logic [15:0]      message_type;
        logic [15:0]      message_length;
        logic             cand_valid;
        logic [OFF_W-1:0] cand_end;
        logic [31:0]      cand_addr;
        logic [15:0]      cand_port;
        logic             cand_xor;
    } srp_snap_t;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = COOKIE_VAL[31:24];
            2'd1:    b = COOKIE_VAL[23:16];
            2'd2:    b = COOKIE_VAL[15:8];
            default: b = COOKIE_VAL[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [OFF_W-1:0] sat_off(input logic [OFF_W:0] v);
        return (v > {1'b0, OFF_SAT}) ? OFF_SAT : v[OFF_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stun_response_parser.sv
// stun_response_parser: top level, input register, parser and result register
// depends on srp_pkg, srp_parse, srp_verdict
`timescale 1ns / 1ps
`default_nettype none

// Takes a received UDP datagram one byte per request and, on the request that
// carries last_byte, returns one result: whether the datagram is a STUN binding
// success response with a usable IPv4 mapped address, a status code, and the
// address and port (un-XORed for XOR-MAPPED-ADDRESS). Throughput is one byte per
// clock unless a last byte waits for a full result register; a byte passes an
// input register and the parser logic, and a last byte's result is loaded into
// the output register. Bytes that carry no result keep flowing while a finished
// result waits in the output register; only a last byte waits for that register
// to drain. Bytes beyond MAX_PACKET are ignored.
module stun_response_parser #(
    parameter int unsigned MAX_PACKET = 512
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire srp_pkg::srp_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output srp_pkg::srp_out_t     out_data
);

    logic               in_valid_reg, in_valid_next;
    srp_pkg::srp_in_t   in_reg;
    logic               out_valid_reg, out_valid_next;
    srp_pkg::srp_out_t  out_reg;

    logic               advance;
    logic               emit;
    srp_pkg::srp_snap_t snap;
    srp_pkg::srp_out_t  result;

    // a last byte needs a free result slot, other bytes never stall
    assign advance  = in_valid_reg
                   && (!in_reg.last_byte || !out_valid_reg || out_ready);
    assign emit     = advance && in_reg.last_byte;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    srp_parse #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_reg),
        .snap    (snap)
    );

    srp_verdict u_verdict (
        .snap   (snap),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
        if (emit)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/srp_parse.sv
// srp_parse: per-byte header check and attribute walk state
// depends on srp_pkg
`timescale 1ns / 1ps
`default_nettype none

module srp_parse #(
    parameter int unsigned MAX_PACKET = 512
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire srp_pkg::srp_in_t    byte_in,
    output srp_pkg::srp_snap_t       snap
);

    localparam int unsigned CNT_W = $clog2(MAX_PACKET + 1);
    localparam int unsigned OW    = srp_pkg::OFF_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             cookie_ok_reg, cookie_ok_next;
    logic [15:0]      msg_type_reg, msg_type_next;
    logic [15:0]      msg_len_reg, msg_len_next;
    logic [OW-1:0]    next_off_reg, next_off_next;
    logic [15:0]      attr_type_reg, attr_type_next;
    logic [15:0]      attr_len_reg, attr_len_next;
    logic             cand_valid_reg, cand_valid_next;
    logic [OW-1:0]    cand_end_reg, cand_end_next;
    logic [31:0]      cand_addr_reg, cand_addr_next;
    logic [15:0]      cand_port_reg, cand_port_next;
    logic             cand_xor_reg, cand_xor_next;

    logic [OW:0]      ix;
    logic [OW:0]      off;
    logic [7:0]       d;
    logic [15:0]      len_new;
    logic             addr_type;
    logic [OW:0]      pad_new;
    logic [OW:0]      pad_old;
    logic [OW:0]      walk_limit;

    assign d          = byte_in.data_byte;
    assign ix         = (OW+1)'(byte_count_reg);
    assign off        = {1'b0, next_off_reg};
    assign len_new    = {attr_len_reg[7:0], d};
    assign addr_type  = (attr_type_reg == srp_pkg::ATTR_XOR_MAPPED)
                     || (attr_type_reg == srp_pkg::ATTR_MAPPED);
    // attribute value length rounded up to a 4-byte boundary
    assign pad_new    = ({2'b00, len_new} + (OW+1)'(3)) & ~(OW+1)'(3);
    assign pad_old    = ({2'b00, attr_len_reg} + (OW+1)'(3)) & ~(OW+1)'(3);
    assign walk_limit = {1'b0, srp_pkg::HDR_LEN} + {2'b00, msg_len_reg};

    always_comb
    begin
        byte_count_next = byte_count_reg;
        cookie_ok_next  = cookie_ok_reg;
        msg_type_next   = msg_type_reg;
        msg_len_next    = msg_len_reg;
        next_off_next   = next_off_reg;
        attr_type_next  = attr_type_reg;
        attr_len_next   = attr_len_reg;
        cand_valid_next = cand_valid_reg;
        cand_end_next   = cand_end_reg;
        cand_addr_next  = cand_addr_reg;
        cand_port_next  = cand_port_reg;
        cand_xor_next   = cand_xor_reg;

        // bytes past the packet store are dropped
        if (step && (byte_count_reg < CNT_MAX))
        begin
            byte_count_next = byte_count_reg + CNT_W'(1);
            if (ix < (OW+1)'(2))
            begin
                msg_type_next = {msg_type_reg[7:0], d};
            end
            else if (ix < (OW+1)'(4))
            begin
                msg_len_next = {msg_len_reg[7:0], d};
            end
            else if (ix < (OW+1)'(8))
            begin
                if (d != srp_pkg::cookie_byte(ix[1:0]))
                begin
                    cookie_ok_next = 1'b0;
                end
            end
            else if (ix < (OW+1)'(20))
            begin
                // transaction id, not checked
            end
            else if (cand_valid_reg)
            begin
                if ((ix >= off + (OW+1)'(6)) && (ix <= off + (OW+1)'(7)))
                begin
                    cand_port_next = {cand_port_reg[7:0], d};
                end
                else if ((ix >= off + (OW+1)'(8)) && (ix <= off + (OW+1)'(11)))
                begin
                    cand_addr_next = {cand_addr_reg[23:0], d};
                end
            end
            else if (off + (OW+1)'(4) > walk_limit)
            begin
                // no room for another attribute header
            end
            else if ((ix == off) || (ix == off + (OW+1)'(1)))
            begin
                attr_type_next = {attr_type_reg[7:0], d};
            end
            else if (ix == off + (OW+1)'(2))
            begin
                attr_len_next = {8'h00, d};
            end
            else if (ix == off + (OW+1)'(3))
            begin
                attr_len_next = len_new;
                if (!(addr_type && (len_new >= srp_pkg::MIN_ADDR_LEN)))
                begin
                    next_off_next = srp_pkg::sat_off(off + (OW+1)'(4) + pad_new);
                end
            end
            else if (ix == off + (OW+1)'(5))
            begin
                if (d == srp_pkg::FAMILY_IPV4)
                begin
                    cand_valid_next = 1'b1;
                    cand_xor_next   = (attr_type_reg == srp_pkg::ATTR_XOR_MAPPED);
                    cand_end_next   = srp_pkg::sat_off(off + (OW+1)'(4)
                                                       + {2'b00, attr_len_reg});
                end
                else
                begin
                    next_off_next = srp_pkg::sat_off(off + (OW+1)'(4) + pad_old);
                end
            end
        end

        snap.pkt_len        = OW'(byte_count_next);
        snap.cookie_ok      = cookie_ok_next;
        snap.message_type   = msg_type_next;
        snap.message_length = msg_len_next;
        snap.cand_valid     = cand_valid_next;
        snap.cand_end       = cand_end_next;
        snap.cand_addr      = cand_addr_next;
        snap.cand_port      = cand_port_next;
        snap.cand_xor       = cand_xor_next;

        // the datagram is done: start over for the next one
        if (step && byte_in.last_byte)
        begin
            byte_count_next = '0;
            cookie_ok_next  = 1'b1;
            msg_type_next   = '0;
            msg_len_next    = '0;
            next_off_next   = srp_pkg::HDR_LEN;
            attr_type_next  = '0;
            attr_len_next   = '0;
            cand_valid_next = 1'b0;
            cand_end_next   = '0;
            cand_addr_next  = '0;
            cand_port_next  = '0;
            cand_xor_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            cookie_ok_reg  <= 1'b1;
            msg_type_reg   <= '0;
            msg_len_reg    <= '0;
            next_off_reg   <= srp_pkg::HDR_LEN;
            attr_type_reg  <= '0;
            attr_len_reg   <= '0;
            cand_valid_reg <= 1'b0;
            cand_end_reg   <= '0;
            cand_addr_reg  <= '0;
            cand_port_reg  <= '0;
            cand_xor_reg   <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            cookie_ok_reg  <= cookie_ok_next;
            msg_type_reg   <= msg_type_next;
            msg_len_reg    <= msg_len_next;
            next_off_reg   <= next_off_next;
            attr_type_reg  <= attr_type_next;
            attr_len_reg   <= attr_len_next;
            cand_valid_reg <= cand_valid_next;
            cand_end_reg   <= cand_end_next;
            cand_addr_reg  <= cand_addr_next;
            cand_port_reg  <= cand_port_next;
            cand_xor_reg   <= cand_xor_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/srp_verdict.sv
// srp_verdict: turns the end-of-datagram parser state into a result
// depends on srp_pkg
`timescale 1ns / 1ps
`default_nettype none

module srp_verdict (
    input  wire srp_pkg::srp_snap_t snap,
    output srp_pkg::srp_out_t       result
);

    localparam int unsigned OW = srp_pkg::OFF_W;

    srp_pkg::srp_status_t status;
    logic [OW-1:0]        need_len;
    logic                 found;

    assign need_len = {1'b0, snap.message_length} + srp_pkg::HDR_LEN;

    // first failing check wins
    always_comb
    begin
        if (snap.pkt_len < srp_pkg::HDR_LEN)
            status = srp_pkg::ST_SHORT;
        else if (!snap.cookie_ok)
            status = srp_pkg::ST_COOKIE;
        else if (snap.message_type != srp_pkg::TYPE_BIND_RESP)
            status = srp_pkg::ST_TYPE;
        else if (need_len > snap.pkt_len)
            status = srp_pkg::ST_OVERRUN;
        else if (snap.cand_valid && (snap.cand_end <= snap.pkt_len))
            status = srp_pkg::ST_OK;
        else
            status = srp_pkg::ST_NO_ADDR;
    end

    assign found = (status == srp_pkg::ST_OK);

    always_comb
    begin
        result.found          = found;
        result.status         = status;
        result.mapped_address = '0;
        result.mapped_port    = '0;
        result.was_xored      = 1'b0;
        if (found)
        begin
            result.was_xored = snap.cand_xor;
            if (snap.cand_xor)
            begin
                result.mapped_address = snap.cand_addr ^ srp_pkg::COOKIE_VAL;
                result.mapped_port    = snap.cand_port ^ srp_pkg::COOKIE_VAL[31:16];
            end
            else
            begin
                result.mapped_address = snap.cand_addr;
                result.mapped_port    = snap.cand_port;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/srp_checker.sv
// srp_checker: port-level checks on the stun response parser, bound to the top
// depends on srp_pkg and stun_response_parser
`timescale 1ns / 1ps
`default_nettype none

module srp_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire srp_pkg::srp_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire srp_pkg::srp_out_t out_data
);

    // with no result pending, a byte is never refused
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("byte refused while result register empty");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.found == (out_data.status == srp_pkg::ST_OK)))
        else $error("found flag disagrees with status");

    a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |->
            (out_data.mapped_address == '0) && (out_data.mapped_port == '0)
            && !out_data.was_xored)
        else $error("address fields set without a found address");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status <= srp_pkg::ST_NO_ADDR))
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind stun_response_parser srp_checker u_srp_checker (.*);

`default_nettype wire
